// File: rtl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// shared types, codes and constants of the work/span profiler
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int REQ_W           = 4;
	localparam int TIME_W          = 64;
	localparam int DEPTH_OUT_W     = 7;
	localparam int ERR_W           = 2;

	// event codes
	localparam logic [REQ_W-1:0] REQ_INIT        = 4'd0;
	localparam logic [REQ_W-1:0] REQ_ENTER_SPAWN = 4'd1;
	localparam logic [REQ_W-1:0] REQ_ENTER_HELP  = 4'd2;
	localparam logic [REQ_W-1:0] REQ_ENTER_END   = 4'd3;
	localparam logic [REQ_W-1:0] REQ_SPAWN_PREP  = 4'd4;
	localparam logic [REQ_W-1:0] REQ_CONTINUE    = 4'd5;
	localparam logic [REQ_W-1:0] REQ_SYNC_BEGIN  = 4'd6;
	localparam logic [REQ_W-1:0] REQ_SYNC_END    = 4'd7;
	localparam logic [REQ_W-1:0] REQ_LEAVE_BEGIN = 4'd8;
	localparam logic [REQ_W-1:0] REQ_REPORT      = 4'd9;

	// frame kinds
	localparam logic [1:0] KIND_MAIN   = 2'd0;
	localparam logic [1:0] KIND_SPAWN  = 2'd1;
	localparam logic [1:0] KIND_HELPER = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
	localparam logic [ERR_W-1:0] ERR_LAST  = 2'd2;
	localparam logic [ERR_W-1:0] ERR_ORDER = 2'd3;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] prefix;
		logic [TIME_W-1:0] longest;
		logic [TIME_W-1:0] cont;
	} frame_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STRAND,
		ST_APPLY,
		ST_MERGE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic strand;
		logic apply;
		logic merge;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	function automatic frame_t empty_frame(input logic [1:0] kind);
		frame_t f;
		f.kind    = kind;
		f.prefix  = '0;
		f.longest = '0;
		f.cont    = '0;
		return f;
	endfunction

endpackage

// File: rtl/wsp_ctrl.sv
// ----------------------------------------------------------------------------
// wsp_ctrl
// sequencer: steps one event through load, strand, apply, merge and emit
// ----------------------------------------------------------------------------
module wsp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wsp_pkg::status_t status,
	output wsp_pkg::cmd_t    cmd
);

	wsp_pkg::state_t state_q;
	wsp_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			wsp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_n     = wsp_pkg::ST_LOAD;
				end
			end
			wsp_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_n  = wsp_pkg::ST_STRAND;
			end
			wsp_pkg::ST_STRAND: begin
				cmd.strand = 1'b1;
				state_n    = wsp_pkg::ST_APPLY;
			end
			wsp_pkg::ST_APPLY: begin
				cmd.apply = 1'b1;
				state_n   = wsp_pkg::ST_MERGE;
			end
			wsp_pkg::ST_MERGE: begin
				cmd.merge = 1'b1;
				state_n   = wsp_pkg::ST_EMIT;
			end
			wsp_pkg::ST_EMIT: begin
				// hold until the output register is free
				if (!status.out_busy) begin
					cmd.emit = 1'b1;
					state_n  = wsp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = wsp_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/wsp_dp.sv
// ----------------------------------------------------------------------------
// wsp_dp
// datapath: top frame registers, frame stack memory, sums and result register
// ----------------------------------------------------------------------------
module wsp_dp #(
	parameter int STACK_DEPTH = wsp_pkg::STACK_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wsp_pkg::cmd_t                    cmd,
	output wsp_pkg::status_t                 status,
	input  logic [wsp_pkg::REQ_W-1:0]        in_req,
	input  logic [wsp_pkg::TIME_W-1:0]       in_time,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [wsp_pkg::TIME_W-1:0]       out_work,
	output logic [wsp_pkg::TIME_W-1:0]       out_span,
	output logic [wsp_pkg::DEPTH_OUT_W-1:0]  out_depth,
	output logic [wsp_pkg::ERR_W-1:0]        out_err
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// frames below the top one; the top frame lives in top_q
	wsp_pkg::frame_t mem [STACK_DEPTH];

	// control state
	logic [CW-1:0]                count_q, count_n;
	logic [wsp_pkg::TIME_W-1:0]   work_q, work_n;
	logic [wsp_pkg::TIME_W-1:0]   start_q, start_n;
	logic                         user_q, user_n;
	logic                         started_q, started_n;
	logic                         out_valid_q, out_valid_n;

	// payload
	wsp_pkg::frame_t              top_q, top_n;
	wsp_pkg::frame_t              rd_q;
	logic [wsp_pkg::REQ_W-1:0]    req_q, req_n;
	logic [wsp_pkg::TIME_W-1:0]   now_q, now_n;
	logic [wsp_pkg::TIME_W-1:0]   t_q, t_n;
	logic [wsp_pkg::TIME_W-1:0]   child_q, child_n;
	logic [wsp_pkg::ERR_W-1:0]    err_q, err_n;
	logic                         pop_q, pop_n;
	logic                         pop_spawn_q, pop_spawn_n;
	logic [wsp_pkg::TIME_W-1:0]   ow_q, ow_n;
	logic [wsp_pkg::TIME_W-1:0]   os_q, os_n;
	logic [wsp_pkg::DEPTH_OUT_W-1:0] od_q, od_n;
	logic [wsp_pkg::ERR_W-1:0]    oe_q, oe_n;

	logic                         wr_en;
	logic [AW-1:0]                wr_addr;
	wsp_pkg::frame_t              wr_data;
	logic [AW-1:0]                rd_addr;

	assign rd_addr          = AW'(count_q - CW'(2));
	assign status.out_busy  = out_valid_q && !out_ready;
	assign out_valid        = out_valid_q;
	assign out_work         = ow_q;
	assign out_span         = os_q;
	assign out_depth        = od_q;
	assign out_err          = oe_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.load) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_comb begin
		logic        ok;
		logic        close;
		logic        push;
		logic [1:0]  push_kind;
		logic [wsp_pkg::TIME_W-1:0] merged;

		count_n     = count_q;
		work_n      = work_q;
		start_n     = start_q;
		user_n      = user_q;
		started_n   = started_q;
		out_valid_n = out_valid_q && !out_ready;
		top_n       = top_q;
		req_n       = req_q;
		now_n       = now_q;
		t_n         = t_q;
		child_n     = child_q;
		err_n       = err_q;
		pop_n       = pop_q;
		pop_spawn_n = pop_spawn_q;
		ow_n        = ow_q;
		os_n        = os_q;
		od_n        = od_q;
		oe_n        = oe_q;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = top_q;
		push        = 1'b0;
		push_kind   = wsp_pkg::KIND_SPAWN;
		merged      = '0;

		ok = (req_q == wsp_pkg::REQ_INIT) ||
		     ((req_q <= wsp_pkg::REQ_REPORT) &&
		      (started_q || (req_q == wsp_pkg::REQ_ENTER_SPAWN)));

		close = 1'b0;
		if (ok) begin
			case (req_q)
				wsp_pkg::REQ_ENTER_SPAWN:
					close = started_q && (top_q.kind != wsp_pkg::KIND_HELPER);
				wsp_pkg::REQ_SPAWN_PREP:
					close = 1'b1;
				wsp_pkg::REQ_SYNC_BEGIN:
					close = (top_q.kind == wsp_pkg::KIND_SPAWN);
				wsp_pkg::REQ_LEAVE_BEGIN:
					close = (count_q > CW'(1)) && (top_q.kind == wsp_pkg::KIND_SPAWN);
				default:
					close = 1'b0;
			endcase
		end

		if (cmd.capture) begin
			req_n = in_req;
			now_n = in_time;
		end

		if (cmd.load) begin
			t_n = now_q - start_q;
		end

		// charge the open strand
		if (cmd.strand && close) begin
			work_n     = work_q + t_q;
			top_n.cont = top_q.cont + t_q;
		end

		if (cmd.apply) begin
			err_n       = wsp_pkg::ERR_OK;
			pop_n       = 1'b0;
			pop_spawn_n = (top_q.kind == wsp_pkg::KIND_SPAWN);
			if (!ok) begin
				err_n = wsp_pkg::ERR_ORDER;
			end else begin
				case (req_q)
					wsp_pkg::REQ_INIT: begin
						top_n     = wsp_pkg::empty_frame(wsp_pkg::KIND_MAIN);
						count_n   = CW'(1);
						work_n    = '0;
						start_n   = now_q;
						user_n    = 1'b1;
						started_n = 1'b1;
					end
					wsp_pkg::REQ_ENTER_SPAWN: begin
						if (!started_q) begin
							top_n     = wsp_pkg::empty_frame(wsp_pkg::KIND_MAIN);
							count_n   = CW'(1);
							work_n    = '0;
							start_n   = now_q;
							user_n    = 1'b0;
							started_n = 1'b1;
						end else if (top_q.kind != wsp_pkg::KIND_HELPER) begin
							user_n = 1'b0;
						end else if (user_q) begin
							err_n = wsp_pkg::ERR_ORDER;
						end
						push      = 1'b1;
						push_kind = wsp_pkg::KIND_SPAWN;
					end
					wsp_pkg::REQ_ENTER_HELP: begin
						user_n    = 1'b0;
						push      = 1'b1;
						push_kind = wsp_pkg::KIND_HELPER;
					end
					wsp_pkg::REQ_ENTER_END, wsp_pkg::REQ_CONTINUE: begin
						if (user_q) err_n = wsp_pkg::ERR_ORDER;
						user_n  = 1'b1;
						start_n = now_q;
					end
					wsp_pkg::REQ_SPAWN_PREP: begin
						if (!user_q) err_n = wsp_pkg::ERR_ORDER;
						user_n = 1'b0;
					end
					wsp_pkg::REQ_SYNC_BEGIN: begin
						if (top_q.kind == wsp_pkg::KIND_SPAWN) begin
							if (!user_q) err_n = wsp_pkg::ERR_ORDER;
							user_n = 1'b0;
						end
					end
					wsp_pkg::REQ_SYNC_END: begin
						if (top_q.longest > top_q.cont) begin
							top_n.prefix = top_q.prefix + top_q.longest;
						end else begin
							top_n.prefix = top_q.prefix + top_q.cont;
						end
						top_n.longest = '0;
						top_n.cont    = '0;
						if (top_q.kind == wsp_pkg::KIND_SPAWN) begin
							if (user_q) err_n = wsp_pkg::ERR_ORDER;
							user_n  = 1'b1;
							start_n = now_q;
						end
					end
					wsp_pkg::REQ_LEAVE_BEGIN: begin
						if (count_q <= CW'(1)) begin
							err_n = wsp_pkg::ERR_LAST;
						end else begin
							if (!user_q || (top_q.longest != '0)) err_n = wsp_pkg::ERR_ORDER;
							user_n  = 1'b0;
							child_n = top_q.prefix + top_q.cont;
							pop_n   = 1'b1;
						end
					end
					default: begin
						// report leaves everything as it is
					end
				endcase
			end

			// push the current top into the stack memory
			if (push) begin
				if (count_n >= CW'(STACK_DEPTH)) begin
					err_n = wsp_pkg::ERR_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_addr = AW'(count_n - CW'(1));
					wr_data = top_n;
					top_n   = wsp_pkg::empty_frame(push_kind);
					count_n = count_n + CW'(1);
				end
			end
		end

		// pop: the parent comes back from memory and takes the child span
		if (cmd.merge && pop_q) begin
			top_n   = rd_q;
			count_n = count_q - CW'(1);
			if (pop_spawn_q) begin
				top_n.cont = rd_q.cont + child_q;
			end else begin
				merged = rd_q.cont + child_q;
				if (merged > rd_q.longest) begin
					top_n.prefix  = rd_q.prefix + rd_q.cont;
					top_n.longest = child_q;
					top_n.cont    = '0;
				end
			end
		end

		if (cmd.emit) begin
			out_valid_n = 1'b1;
			ow_n        = work_q;
			os_n        = (count_q == '0) ? '0 : (top_q.prefix + top_q.cont);
			od_n        = wsp_pkg::DEPTH_OUT_W'(count_q);
			oe_n        = err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			work_q      <= '0;
			start_q     <= '0;
			user_q      <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_n;
			work_q      <= work_n;
			start_q     <= start_n;
			user_q      <= user_n;
			started_q   <= started_n;
			out_valid_q <= out_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		top_q       <= top_n;
		req_q       <= req_n;
		now_q       <= now_n;
		t_q         <= t_n;
		child_q     <= child_n;
		err_q       <= err_n;
		pop_q       <= pop_n;
		pop_spawn_q <= pop_spawn_n;
		ow_q        <= ow_n;
		os_q        <= os_n;
		od_q        <= od_n;
		oe_q        <= oe_n;
	end

endmodule

// File: rtl/work_span_profiler.sv
// ----------------------------------------------------------------------------
// work_span_profiler
// work and span accounting over a stream of timestamped runtime events
// ----------------------------------------------------------------------------
// one event word enters on the slave side: event code in s_tuser, timestamp
// in s_tdata. exactly one result word leaves on the master side per event,
// carrying running work, current span, stack depth and an error code.
// an event is taken only while the block is idle; it then steps through
// load (parent frame read from the stack memory, strand time formed),
// strand charge, apply, merge and emit, and the block is ready again
// once emit has passed; the result shows on m_tvalid from the output
// register that the emit step writes.
// the result waits in an output register: the next event is taken while
// the previous result is still pending, and a stalled receiver only holds
// the emit step of the following event.
// reset clears the depth, work, strand start and flags; frame contents are
// undefined until written, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module work_span_profiler #(
	parameter int STACK_DEPTH = wsp_pkg::STACK_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// event words in
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // [63:0] timestamp_ns
	input  logic [3:0]   s_tuser,   // [3:0] req_type
	// result words out
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata    // [63:0] total_work, [127:64] total_span,
	                                // [134:128] stack_depth, [136:135] error_code
);

	wsp_pkg::cmd_t    cmd;
	wsp_pkg::status_t status;

	logic [wsp_pkg::TIME_W-1:0]      work;
	logic [wsp_pkg::TIME_W-1:0]      span;
	logic [wsp_pkg::DEPTH_OUT_W-1:0] depth;
	logic [wsp_pkg::ERR_W-1:0]       err;

	// sequencer
	wsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// frame stack and sums
	wsp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_req    (s_tuser),
		.in_time   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_work  (work),
		.out_span  (span),
		.out_depth (depth),
		.out_err   (err)
	);

	// pack result word, zero padded to whole bytes
	assign m_tdata = {7'd0, err, depth, span, work};

endmodule

// File: verif/work_span_profiler_test.sv
// ----------------------------------------------------------------------------
// work_span_profiler_test
// checks event words against a cycle-free model of the work/span stack
// ----------------------------------------------------------------------------
// a driver feeds event words from a queue, a monitor compares every result
// word with the oldest prediction; sender and receiver stall at random in
// three phases with different stall rates
// ----------------------------------------------------------------------------
module work_span_profiler_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH     = wsp_pkg::STACK_DEPTH_DEF;
	localparam int WDOG_MAX  = 20000;

	typedef struct packed {
		logic [3:0]  req;
		logic [63:0] ts;
	} event_t;

	// lowest field last, matching the result word layout
	typedef struct packed {
		logic [1:0]  err;
		logic [6:0]  depth;
		logic [63:0] span;
		logic [63:0] work;
	} result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;   // [63:0] timestamp_ns
	logic [3:0]   s_tuser;   // [3:0] req_type
	logic         m_tvalid;
	logic         m_tready;
	logic [143:0] m_tdata;   // [63:0] work, [127:64] span, [134:128] depth, [136:135] err

	work_span_profiler u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// predictor state, mirrors the profiler's stack
	logic [1:0]  fk [DEPTH];
	logic [63:0] fpre [DEPTH];
	logic [63:0] flong [DEPTH];
	logic [63:0] fcont [DEPTH];
	int unsigned nframes;
	logic [63:0] work_acc;
	logic [63:0] strand_t0;
	logic        in_user;
	logic        started;

	event_t  pending_events [$];
	result_t expected_results [$];

	int  mismatches;
	int  n_words_in;
	int  n_words_out;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  wdog;

	// model clock time seen by the generator, mostly moving forward with occasional jumps
	logic [63:0] gen_now;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_frame(int unsigned i, logic [1:0] k);
		fk[i] = k;
		fpre[i] = '0;
		flong[i] = '0;
		fcont[i] = '0;
	endfunction

	function automatic void charge_strand(logic [63:0] now);
		logic [63:0] t;
		t = now - strand_t0;
		work_acc += t;
		fcont[nframes-1] += t;
	endfunction

	function automatic logic push_frame(logic [1:0] k);
		if (nframes >= DEPTH)
			return 1'b1;
		clear_frame(nframes, k);
		nframes++;
		return 1'b0;
	endfunction

	function automatic void restart_stack(logic [63:0] now, logic user);
		clear_frame(0, wsp_pkg::KIND_MAIN);
		nframes   = 1;
		work_acc  = '0;
		strand_t0 = now;
		in_user   = user;
		started   = 1'b1;
	endfunction

	// one event through the profiler model
	function automatic result_t profile_event(event_t ev);
		result_t r;
		logic [1:0] e;
		int unsigned top, p;
		logic [63:0] child;
		e = wsp_pkg::ERR_OK;
		if (ev.req == wsp_pkg::REQ_INIT) begin
			restart_stack(ev.ts, 1'b1);
		end else if (ev.req > wsp_pkg::REQ_REPORT) begin
			e = wsp_pkg::ERR_ORDER;
		end else if (!started && ev.req != wsp_pkg::REQ_ENTER_SPAWN) begin
			e = wsp_pkg::ERR_ORDER;
		end else begin
			top = nframes - 1;
			case (ev.req)
				wsp_pkg::REQ_ENTER_SPAWN: begin
					if (!started) begin
						restart_stack(ev.ts, 1'b0);
					end else if (fk[top] != wsp_pkg::KIND_HELPER) begin
						charge_strand(ev.ts);
						in_user = 1'b0;
					end else if (in_user) begin
						e = wsp_pkg::ERR_ORDER;
					end
					if (push_frame(wsp_pkg::KIND_SPAWN)) e = wsp_pkg::ERR_FULL;
				end
				wsp_pkg::REQ_ENTER_HELP: begin
					in_user = 1'b0;
					if (push_frame(wsp_pkg::KIND_HELPER)) e = wsp_pkg::ERR_FULL;
				end
				wsp_pkg::REQ_ENTER_END, wsp_pkg::REQ_CONTINUE: begin
					if (in_user) e = wsp_pkg::ERR_ORDER;
					in_user = 1'b1;
					strand_t0 = ev.ts;
				end
				wsp_pkg::REQ_SPAWN_PREP: begin
					charge_strand(ev.ts);
					if (!in_user) e = wsp_pkg::ERR_ORDER;
					in_user = 1'b0;
				end
				wsp_pkg::REQ_SYNC_BEGIN: begin
					if (fk[top] == wsp_pkg::KIND_SPAWN) begin
						charge_strand(ev.ts);
						if (!in_user) e = wsp_pkg::ERR_ORDER;
						in_user = 1'b0;
					end
				end
				wsp_pkg::REQ_SYNC_END: begin
					fpre[top] += (flong[top] > fcont[top]) ? flong[top] : fcont[top];
					flong[top] = '0;
					fcont[top] = '0;
					if (fk[top] == wsp_pkg::KIND_SPAWN) begin
						if (in_user) e = wsp_pkg::ERR_ORDER;
						in_user = 1'b1;
						strand_t0 = ev.ts;
					end
				end
				wsp_pkg::REQ_LEAVE_BEGIN: begin
					if (nframes <= 1) begin
						e = wsp_pkg::ERR_LAST;
					end else begin
						if (!in_user) e = wsp_pkg::ERR_ORDER;
						in_user = 1'b0;
						if (flong[top] != '0) e = wsp_pkg::ERR_ORDER;
						p = top - 1;
						if (fk[top] == wsp_pkg::KIND_SPAWN) begin
							charge_strand(ev.ts);
							fpre[top] += fcont[top];
							child = fpre[top];
							nframes--;
							fcont[p] += child;
						end else begin
							fpre[top] += fcont[top];
							child = fpre[top];
							nframes--;
							if (fcont[p] + child > flong[p]) begin
								fpre[p] += fcont[p];
								flong[p] = child;
								fcont[p] = '0;
							end
						end
					end
				end
				default: ;  // report, started here so no error
			endcase
		end
		r.work  = work_acc;
		r.span  = (nframes == 0) ? 64'd0 : fpre[nframes-1] + fcont[nframes-1];
		r.depth = nframes[6:0];
		r.err   = e;
		return r;
	endfunction

	// timestamp that mostly moves forward by a small step
	function automatic logic [63:0] next_ts();
		case ($urandom_range(0, 19))
			0: gen_now = {$urandom, $urandom};
			1: gen_now = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 50);
			default: gen_now = gen_now + $urandom_range(0, 1000);
		endcase
		return gen_now;
	endfunction

	task automatic queue_event(logic [3:0] req, logic [63:0] ts);
		event_t ev;
		ev.req = req;
		ev.ts  = ts;
		pending_events.push_back(ev);
	endtask

	// a well-formed spawn: prepare, enter, body, leave, continue
	task automatic queue_spawn(int lvl);
		int n;
		queue_event(wsp_pkg::REQ_SPAWN_PREP, next_ts());
		queue_event(wsp_pkg::REQ_ENTER_SPAWN, next_ts());
		queue_event(wsp_pkg::REQ_ENTER_END, next_ts());
		n = (lvl < 3) ? $urandom_range(0, 2) : 0;
		repeat (n) queue_spawn(lvl + 1);
		if (n != 0) begin
			queue_event(wsp_pkg::REQ_SYNC_BEGIN, next_ts());
			queue_event(wsp_pkg::REQ_SYNC_END, next_ts());
		end
		queue_event(wsp_pkg::REQ_LEAVE_BEGIN, next_ts());
		queue_event(wsp_pkg::REQ_ENTER_END, next_ts());
		queue_event(wsp_pkg::REQ_CONTINUE, next_ts());
	endtask

	// random part: mostly well-formed programs, some helpers and noise
	task automatic queue_random(int target);
		while (pending_events.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1: queue_event(4'($urandom_range(0, 15)), next_ts());
				2: begin
					queue_event(wsp_pkg::REQ_ENTER_HELP, next_ts());
					queue_event(wsp_pkg::REQ_ENTER_SPAWN, next_ts());
					queue_event(wsp_pkg::REQ_ENTER_END, next_ts());
					queue_event(wsp_pkg::REQ_LEAVE_BEGIN, next_ts());
					queue_event(wsp_pkg::REQ_LEAVE_BEGIN, next_ts());
				end
				3: queue_event(wsp_pkg::REQ_INIT, next_ts());
				4: queue_event(wsp_pkg::REQ_REPORT, next_ts());
				default: begin
					queue_spawn(0);
					queue_event(wsp_pkg::REQ_SYNC_BEGIN, next_ts());
					queue_event(wsp_pkg::REQ_SYNC_END, next_ts());
				end
			endcase
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		event_t ev;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(profile_event({s_tuser, s_tdata}));
				n_words_in++;
			end
			if ((!s_tvalid || s_tready) && pending_events.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				ev = pending_events.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= ev.req;
				s_tdata  <= ev.ts;
			end else if (s_tready) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[136:0];
				n_words_out++;
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: result word with none expected: %h", $realtime, got);
				end else begin
					want = expected_results.pop_front();
					if (got.work !== want.work) begin
						mismatches++;
						$display("%0t: work exp %h got %h", $realtime, want.work, got.work);
					end
					if (got.span !== want.span) begin
						mismatches++;
						$display("%0t: span exp %h got %h", $realtime, want.span, got.span);
					end
					if (got.depth !== want.depth) begin
						mismatches++;
						$display("%0t: depth exp %0d got %0d", $realtime, want.depth, got.depth);
					end
					if (got.err !== want.err) begin
						mismatches++;
						$display("%0t: error exp %0d got %0d", $realtime, want.err, got.err);
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				wdog <= 0;
			else
				wdog <= wdog + 1;
			if (wdog >= WDOG_MAX) begin
				$display("%0t: watchdog expired", $realtime);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int k;
		arst_n = 1'b0;
		mismatches = 0;
		n_words_in = 0;
		n_words_out = 0;
		wdog = 0;
		send_idle_pct = 24;
		recv_idle_pct = 66;
		gen_now = '0;
		nframes = 0;
		work_acc = '0;
		strand_t0 = '0;
		in_user = 1'b0;
		started = 1'b0;
		for (k = 0; k < DEPTH; k++) clear_frame(k, wsp_pkg::KIND_MAIN);

		// directed: events before start, bad codes, first spawn as init
		queue_event(wsp_pkg::REQ_REPORT, 64'd0);
		queue_event(wsp_pkg::REQ_SYNC_END, 64'd5);
		queue_event(4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_event(wsp_pkg::REQ_ENTER_SPAWN, 64'd10);
		queue_event(wsp_pkg::REQ_ENTER_SPAWN, 64'd20);  // flag already clear
		queue_event(wsp_pkg::REQ_LEAVE_BEGIN, 64'd30);  // flag wrong
		queue_event(wsp_pkg::REQ_INIT, 64'hFFFF_FFFF_FFFF_FF00);
		queue_event(wsp_pkg::REQ_SPAWN_PREP, 64'd100);  // strand wraps
		queue_event(wsp_pkg::REQ_LEAVE_BEGIN, 64'd110); // only one frame
		queue_event(wsp_pkg::REQ_ENTER_HELP, 64'd120);
		queue_event(wsp_pkg::REQ_CONTINUE, 64'd130);
		queue_event(wsp_pkg::REQ_SYNC_BEGIN, 64'd140);
		queue_event(wsp_pkg::REQ_SYNC_END, 64'd150);
		queue_event(wsp_pkg::REQ_LEAVE_BEGIN, 64'd160);
		queue_event(wsp_pkg::REQ_REPORT, 64'd170);
		queue_event(4'hA, 64'd180);
		// fill the stack to overflow
		queue_event(wsp_pkg::REQ_INIT, 64'd200);
		for (k = 0; k < DEPTH + 1; k++) queue_event(wsp_pkg::REQ_ENTER_HELP, 64'd200 + k);
		queue_event(wsp_pkg::REQ_ENTER_SPAWN, 64'd300);
		for (k = 0; k < DEPTH; k++) queue_event(wsp_pkg::REQ_LEAVE_BEGIN, 64'd400 + k);
		gen_now = 64'd1000;
		queue_event(wsp_pkg::REQ_INIT, gen_now);
		queue_random(pending_events.size() + 500);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// three stall phases
		wait (pending_events.size() == 0);
		send_idle_pct = 66;
		recv_idle_pct = 24;
		queue_random(500);
		wait (pending_events.size() == 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(500);
		wait (pending_events.size() == 0);
		@(posedge clk);
		while (s_tvalid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("events sent %0d, results checked %0d, over three stall phases",
			n_words_in, n_words_out);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
